// ===== sv/jse_pkg.sv =====
// Shared types and constants for the JSON string escaper.
// Depends on nothing; every other file of the block imports it.
package jse_pkg;

    // Longest byte run one code unit can cause: '?' followed by a \u00XX escape.
    localparam int MAX_RUN = 7;

    // Width of a run length (0 to MAX_RUN).
    localparam int LEN_W = $clog2(MAX_RUN + 1);

    // Default depth of the run queue between the front and the back.
    localparam int RUN_FIFO_DEPTH = 2;

    // One run of output bytes, byte 0 first.
    typedef struct packed {
        logic [MAX_RUN-1:0][7:0] bytes;
        logic [LEN_W-1:0]        len;
    } run_t;

    // Queue status seen by the top level and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

// ===== sv/jse_front.sv =====
// Front of the escaper: joins surrogate pairs and turns one code unit into a byte run.
// Depends on jse_pkg for the run type.
module jse_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic [15:0]    code_unit,
    input  logic           end_of_string,
    output jse_pkg::run_t  run,
    output logic           push
);
    import jse_pkg::*;

    localparam logic [7:0] CH_QUESTION  = 8'h3f;
    localparam logic [7:0] CH_BACKSLASH = 8'h5c;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6e;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_ZERO      = 8'h30;

    localparam int BODY = MAX_RUN - 1;

    logic [9:0] pend_high_reg;
    logic [9:0] pend_high_next;
    logic       pend_valid_reg;
    logic       pend_valid_next;

    logic        is_low;
    logic        is_high;
    logic        pair;
    logic        prefix;
    logic [20:0] cp;
    logic        do_encode;
    logic [BODY-1:0][7:0] body;
    logic [LEN_W-1:0]     body_len;
    logic [LEN_W-1:0]     total_len;

    // Lower-case hex digit for one nibble.
    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        hex_digit = (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h57 + {4'd0, v});
    endfunction

    // Surrogate classification and code point assembly.
    assign is_low  = (code_unit[15:10] == 6'b110111);
    assign is_high = (code_unit[15:10] == 6'b110110);
    assign pair    = pend_valid_reg && is_low;
    assign prefix  = pend_valid_reg && !is_low;
    assign cp      = pair ? (21'h10000 + {1'b0, pend_high_reg, code_unit[9:0]})
                          : {5'd0, code_unit};
    assign do_encode = pair || (!is_low && !is_high);

    // Encoding of one code point into escape or UTF-8 bytes.
    always_comb
    begin
        body     = '0;
        body_len = '0;
        if (!do_encode)
        begin
            if (is_low && !pair)
            begin
                body[0]  = CH_QUESTION;
                body_len = LEN_W'(1);
            end
        end
        else if (cp < 21'h80)
        begin
            if (cp < 21'h20 || cp == 21'h22 || cp == 21'h5c)
            begin
                body[0]  = CH_BACKSLASH;
                body_len = LEN_W'(2);
                case (cp[7:0])
                    8'h22: body[1] = CH_QUOTE;
                    8'h5c: body[1] = CH_BACKSLASH;
                    8'h08: body[1] = CH_B;
                    8'h0c: body[1] = CH_F;
                    8'h0a: body[1] = CH_N;
                    8'h0d: body[1] = CH_R;
                    8'h09: body[1] = CH_T;
                    default:
                    begin
                        body[1]  = CH_U;
                        body[2]  = CH_ZERO;
                        body[3]  = CH_ZERO;
                        body[4]  = hex_digit(cp[7:4]);
                        body[5]  = hex_digit(cp[3:0]);
                        body_len = LEN_W'(6);
                    end
                endcase
            end
            else
            begin
                body[0]  = cp[7:0];
                body_len = LEN_W'(1);
            end
        end
        else if (cp < 21'h800)
        begin
            body[0]  = 8'hc0 | {3'd0, cp[10:6]};
            body[1]  = 8'h80 | {2'd0, cp[5:0]};
            body_len = LEN_W'(2);
        end
        else if (cp[15:1] == 15'h7fff || (cp >= 21'hfdd0 && cp <= 21'hfdef))
        begin
            // Non-characters are replaced by a single question mark.
            body[0]  = CH_QUESTION;
            body_len = LEN_W'(1);
        end
        else if (cp > 21'hffff)
        begin
            body[0]  = 8'hf0 | {5'd0, cp[20:18]};
            body[1]  = 8'h80 | {2'd0, cp[17:12]};
            body[2]  = 8'h80 | {2'd0, cp[11:6]};
            body[3]  = 8'h80 | {2'd0, cp[5:0]};
            body_len = LEN_W'(4);
        end
        else
        begin
            body[0]  = 8'he0 | {4'd0, cp[15:12]};
            body[1]  = 8'h80 | {2'd0, cp[11:6]};
            body[2]  = 8'h80 | {2'd0, cp[5:0]};
            body_len = LEN_W'(3);
        end
    end

    // An unpaired high surrogate puts a question mark ahead of the body.
    always_comb
    begin
        run.bytes[0] = prefix ? CH_QUESTION : body[0];
        for (int i = 1; i < MAX_RUN; i++)
        begin
            if (i < BODY)
            begin
                run.bytes[i] = prefix ? body[i-1] : body[i];
            end
            else
            begin
                run.bytes[i] = prefix ? body[i-1] : 8'h00;
            end
        end
        total_len = body_len + {{(LEN_W-1){1'b0}}, prefix};
        run.len   = total_len;
    end

    assign push = accept && (total_len != '0);

    // Pending surrogate update; end of string leaves no surrogate pending.
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_high_next  = pend_high_reg;
        if (accept)
        begin
            pend_valid_next = is_high && !end_of_string;
            pend_high_next  = (is_high && !end_of_string) ? code_unit[9:0] : 10'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_high_reg  <= '0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            pend_high_reg  <= pend_high_next;
        end
    end

endmodule

// ===== sv/jse_fifo.sv =====
// Short run queue that decouples the front from the back.
// Depends on jse_pkg for the run and status types.
module jse_fifo #(
    parameter int DEPTH = jse_pkg::RUN_FIFO_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  jse_pkg::run_t         wdata,
    input  logic                  pop,
    output jse_pkg::run_t         head,
    output jse_pkg::fifo_status_t status
);
    import jse_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    run_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // Storage holds payload only, so it takes no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    assign head         = mem[rd_ptr_reg];
    assign status.full  = (cnt_reg == CNT_W'(DEPTH));
    assign status.empty = (cnt_reg == '0);

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== sv/jse_back.sv =====
// Back of the escaper: plays the head run out one byte per output word.
// Depends on jse_pkg for the run and status types.
module jse_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  jse_pkg::run_t         head,
    input  jse_pkg::fifo_status_t status,
    input  logic                  out_stall,
    output logic                  pop,
    output logic                  out_valid,
    output logic [7:0]            out_byte,
    output logic                  run_last
);
    import jse_pkg::*;

    localparam int IDX_W = $clog2(MAX_RUN);

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             take;

    // Byte select from the queue head; the queue registers hold it steady.
    assign out_valid = !status.empty;
    assign out_byte  = head.bytes[idx_reg];
    assign run_last  = (LEN_W'(idx_reg) == head.len - LEN_W'(1));
    assign take      = out_valid && !out_stall;
    assign pop       = take && run_last;

    // Byte index within the run restarts when the run is popped.
    always_comb
    begin
        idx_next = idx_reg;
        if (take)
        begin
            idx_next = run_last ? '0 : idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

// ===== sv/json_string_escape_utf8.sv =====
// JSON string escaper, UTF-16 code units in, escaped UTF-8 bytes out.
// A unit's run is registered in the run queue and is output from its head.
// Throughput: one output byte per cycle while out_stall is low; a unit causing
// N bytes holds the output for all N, so single-byte units flow one per cycle.
// Reset clears the pending surrogate, the run queue and the byte index.
module json_string_escape_utf8 #(
    parameter int FIFO_DEPTH = jse_pkg::RUN_FIFO_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] code_unit,
    input  logic        end_of_string,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        run_last
);
    import jse_pkg::*;

    run_t         front_run;
    run_t         head_run;
    fifo_status_t q_status;
    logic         accept;
    logic         push;
    logic         pop;

    // Input words are held off while the run queue is full.
    assign in_stall = q_status.full;
    assign accept   = in_valid && !in_stall;

    jse_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .code_unit     (code_unit),
        .end_of_string (end_of_string),
        .run           (front_run),
        .push          (push)
    );

    jse_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wdata  (front_run),
        .pop    (pop),
        .head   (head_run),
        .status (q_status)
    );

    jse_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head_run),
        .status    (q_status),
        .out_stall (out_stall),
        .pop       (pop),
        .out_valid (out_valid),
        .out_byte  (out_byte),
        .run_last  (run_last)
    );

endmodule
